// ----- src/coap_pkg.sv -----
// Package: shared constants for the CoAP message parser.
`default_nettype none
package coap_pkg;

  localparam int MaxOptions = 16;
  localparam int OptCntW = $clog2(MaxOptions + 1);

  localparam logic [2:0] RoleHeader  = 3'd0;
  localparam logic [2:0] RoleToken   = 3'd1;
  localparam logic [2:0] RoleOptHead = 3'd2;
  localparam logic [2:0] RoleOptExt  = 3'd3;
  localparam logic [2:0] RoleOptVal  = 3'd4;
  localparam logic [2:0] RoleMarker  = 3'd5;
  localparam logic [2:0] RolePayload = 3'd6;
  localparam logic [2:0] RoleIgnored = 3'd7;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StHdrShort  = 3'd1;
  localparam logic [2:0] StVersion   = 3'd2;
  localparam logic [2:0] StToken     = 3'd3;
  localparam logic [2:0] StOptShort  = 3'd4;
  localparam logic [2:0] StDelta15   = 3'd5;
  localparam logic [2:0] StLength15  = 3'd6;
  localparam logic [2:0] StOptBig    = 3'd7;

  localparam logic [7:0]  PayloadMarker = 8'hFF;
  localparam logic [3:0]  Nib13 = 4'd13;
  localparam logic [3:0]  Nib14 = 4'd14;
  localparam logic [3:0]  Nib15 = 4'd15;
  localparam logic [15:0] Ext1Off = 16'd13;
  localparam logic [15:0] Ext2Off = 16'd269;
  localparam logic [3:0]  MaxTokenLen = 4'd8;

endpackage
`default_nettype wire

// ----- src/coap_message_parser.sv -----
// CoAP message parser: header, token and option framing, one beat per byte.
// The result beat of each accepted input beat is registered and appears in the next cycle.
// Throughput: one byte per cycle; the parse step sits between the parser state and
// a single result register; input stalls only while that result waits on out_stall_i.
// Reset (rst_ni low, asynchronous): parser returns to the header phase, no result valid.
// Parser state also returns to its reset values after each final byte.
`default_nettype none
module coap_message_parser import coap_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       role_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      option_number_o,
  output logic [3:0]       option_slot_o,
  output logic [15:0]      option_length_o,
  output logic             message_end_o,
  output logic [2:0]       status_o,
  output logic [1:0]       message_type_o,
  output logic [3:0]       token_length_o,
  output logic [7:0]       message_code_o,
  output logic [15:0]      message_id_o,
  output logic [4:0]       option_total_o
);

  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhToken   = 3'd1;
  localparam logic [2:0] PhHead    = 3'd2;
  localparam logic [2:0] PhExt     = 3'd3;
  localparam logic [2:0] PhValue   = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;
  localparam logic [2:0] PhIgnore  = 3'd6;

  logic [2:0]         phase_q, phase_d;
  logic [1:0]         header_pos_q, header_pos_d;
  logic [3:0]         token_left_q, token_left_d;
  logic [1:0]         delta_mode_q, delta_mode_d;
  logic [1:0]         length_mode_q, length_mode_d;
  logic [1:0]         ext_count_q, ext_count_d;
  logic [15:0]        delta_acc_q, delta_acc_d;
  logic [15:0]        length_acc_q, length_acc_d;
  logic [15:0]        running_q, running_d;
  logic [15:0]        value_left_q, value_left_d;
  logic [OptCntW-1:0] seen_q, seen_d;
  logic [2:0]         err_q, err_d;
  logic [1:0]         mtype_q, mtype_d;
  logic [3:0]         tkl_q, tkl_d;
  logic [7:0]         code_q, code_d;
  logic [15:0]        mid_q, mid_d;

  logic        out_valid_q;
  logic [2:0]  role_q, role_d;
  logic [7:0]  byte_q;
  logic [15:0] num_q, num_d;
  logic [3:0]  slot_q, slot_d;
  logic [15:0] len_q, len_d;
  logic        end_q;
  logic [2:0]  status_q, status_d;
  logic [1:0]  otype_q, otype_d;
  logic [3:0]  otkl_q, otkl_d;
  logic [7:0]  ocode_q, ocode_d;
  logic [15:0] omid_q, omid_d;
  logic [4:0]  ototal_q, ototal_d;

  logic accept;
  logic [3:0] dn, ln;
  logic [31:0] seen_ext;
  logic dd_go, hd_go, cmp_go;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign dn         = in_byte_i[7:4];
  assign ln         = in_byte_i[3:0];
  assign seen_ext   = 32'(seen_q);

  always_comb begin
    phase_d       = phase_q;
    header_pos_d  = header_pos_q;
    token_left_d  = token_left_q;
    delta_mode_d  = delta_mode_q;
    length_mode_d = length_mode_q;
    ext_count_d   = ext_count_q;
    delta_acc_d   = delta_acc_q;
    length_acc_d  = length_acc_q;
    running_d     = running_q;
    value_left_d  = value_left_q;
    seen_d        = seen_q;
    err_d         = err_q;
    mtype_d       = mtype_q;
    tkl_d         = tkl_q;
    code_d        = code_q;
    mid_d         = mid_q;
    role_d        = RoleIgnored;
    num_d         = '0;
    slot_d        = '0;
    len_d         = '0;
    dd_go         = 1'b0;
    hd_go         = 1'b0;
    cmp_go        = 1'b0;

    case (phase_q)
      PhHeader: begin
        role_d = RoleHeader;
        case (header_pos_q)
          2'd0: begin
            if (in_byte_i[7:6] != 2'd1) err_d = StVersion;
            mtype_d = in_byte_i[5:4];
            tkl_d   = in_byte_i[3:0];
          end
          2'd1: code_d = in_byte_i;
          2'd2: mid_d[15:8] = in_byte_i;
          default: mid_d[7:0] = in_byte_i;
        endcase
        if (header_pos_q == 2'd3) begin
          header_pos_d = 2'd0;
          if (err_q != StOk) begin
            phase_d = PhIgnore;
          end else if (tkl_q > MaxTokenLen) begin
            err_d   = StToken;
            phase_d = PhIgnore;
          end else begin
            token_left_d = tkl_q;
            phase_d      = (tkl_q != 4'd0) ? PhToken : PhHead;
          end
        end else begin
          header_pos_d = header_pos_q + 2'd1;
        end
      end
      PhToken: begin
        role_d       = RoleToken;
        token_left_d = token_left_q - 4'd1;
        if (token_left_d == 4'd0) phase_d = PhHead;
      end
      PhHead: begin
        if (in_byte_i == PayloadMarker) begin
          role_d  = RoleMarker;
          phase_d = PhPayload;
        end else if (seen_ext >= 32'(MaxOptions)) begin
          role_d  = RoleIgnored;
          phase_d = PhIgnore;
        end else begin
          role_d        = RoleOptHead;
          delta_mode_d  = (dn == Nib13) ? 2'd1 : (dn == Nib14) ? 2'd2 : 2'd0;
          delta_acc_d   = (dn < Nib13) ? {12'd0, dn} : 16'd0;
          length_mode_d = (ln == Nib13) ? 2'd1 : (ln == Nib14) ? 2'd2 :
                          (ln == Nib15) ? 2'd3 : 2'd0;
          length_acc_d  = (ln < Nib13) ? {12'd0, ln} : 16'd0;
          num_d         = running_q + delta_acc_d;
          slot_d        = seen_ext[3:0];
          len_d         = length_acc_d;
          if (dn == Nib15) begin
            err_d   = StDelta15;
            phase_d = PhIgnore;
          end else if (delta_mode_d != 2'd0) begin
            ext_count_d = delta_mode_d;
            phase_d     = PhExt;
          end else begin
            dd_go = 1'b1;
          end
        end
      end
      PhExt: begin
        role_d = RoleOptExt;
        slot_d = seen_ext[3:0];
        if (delta_mode_q != 2'd0) begin
          if (ext_count_q == 2'd2) begin
            delta_acc_d = {in_byte_i, 8'd0};
            ext_count_d = 2'd1;
          end else begin
            delta_acc_d  = (delta_mode_q == 2'd1) ? ({8'd0, in_byte_i} + Ext1Off)
                                                  : ((delta_acc_q | {8'd0, in_byte_i}) + Ext2Off);
            delta_mode_d = 2'd0;
            ext_count_d  = 2'd0;
            dd_go        = 1'b1;
          end
          num_d = running_q + delta_acc_d;
          len_d = length_acc_q;
        end else begin
          if (ext_count_q == 2'd2) begin
            length_acc_d = {in_byte_i, 8'd0};
            ext_count_d  = 2'd1;
          end else begin
            length_acc_d  = (length_mode_q == 2'd1) ? ({8'd0, in_byte_i} + Ext1Off)
                                                    : ((length_acc_q | {8'd0, in_byte_i}) + Ext2Off);
            length_mode_d = 2'd0;
            ext_count_d   = 2'd0;
            hd_go         = 1'b1;
          end
          num_d = running_q + delta_acc_q;
          len_d = length_acc_d;
        end
      end
      PhValue: begin
        role_d       = RoleOptVal;
        num_d        = running_q + delta_acc_q;
        slot_d       = seen_ext[3:0];
        len_d        = length_acc_q;
        value_left_d = value_left_q - 16'd1;
        if (value_left_d == 16'd0) cmp_go = 1'b1;
      end
      PhPayload: role_d = RolePayload;
      default:   role_d = RoleIgnored;
    endcase

    // delta complete: dispatch on the length nibble
    if (dd_go) begin
      if (length_mode_d == 2'd3) begin
        err_d   = StLength15;
        phase_d = PhIgnore;
      end else if (length_mode_d != 2'd0) begin
        ext_count_d = length_mode_d;
        phase_d     = PhExt;
      end else begin
        hd_go = 1'b1;
      end
    end
    if (hd_go) begin
      if (length_acc_d == 16'd0) begin
        cmp_go = 1'b1;
      end else begin
        value_left_d = length_acc_d;
        phase_d      = PhValue;
      end
    end
    if (cmp_go) begin
      running_d    = running_q + delta_acc_d;
      seen_d       = seen_q + OptCntW'(1);
      delta_acc_d  = '0;
      length_acc_d = '0;
      phase_d      = PhHead;
    end

    status_d   = StOk;
    otype_d    = '0;
    otkl_d     = '0;
    ocode_d    = '0;
    omid_d     = '0;
    ototal_d   = '0;
    if (in_last_i) begin
      if (phase_d == PhHeader)   status_d = StHdrShort;
      else if (err_d != StOk)    status_d = err_d;
      else if (phase_d == PhToken) status_d = StToken;
      else if (phase_d == PhExt)   status_d = StOptShort;
      else if (phase_d == PhValue) status_d = StOptBig;
      else                         status_d = StOk;
      otype_d  = mtype_d;
      otkl_d   = tkl_d;
      ocode_d  = code_d;
      omid_d   = mid_d;
      ototal_d = 5'(seen_d);
      phase_d       = PhHeader;
      header_pos_d  = '0;
      token_left_d  = '0;
      delta_mode_d  = '0;
      length_mode_d = '0;
      ext_count_d   = '0;
      delta_acc_d   = '0;
      length_acc_d  = '0;
      running_d     = '0;
      value_left_d  = '0;
      seen_d        = '0;
      err_d         = StOk;
      mtype_d       = '0;
      tkl_d         = '0;
      code_d        = '0;
      mid_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHeader;
      header_pos_q  <= '0;
      token_left_q  <= '0;
      delta_mode_q  <= '0;
      length_mode_q <= '0;
      ext_count_q   <= '0;
      delta_acc_q   <= '0;
      length_acc_q  <= '0;
      running_q     <= '0;
      value_left_q  <= '0;
      seen_q        <= '0;
      err_q         <= StOk;
      mtype_q       <= '0;
      tkl_q         <= '0;
      code_q        <= '0;
      mid_q         <= '0;
    end else if (accept) begin
      phase_q       <= phase_d;
      header_pos_q  <= header_pos_d;
      token_left_q  <= token_left_d;
      delta_mode_q  <= delta_mode_d;
      length_mode_q <= length_mode_d;
      ext_count_q   <= ext_count_d;
      delta_acc_q   <= delta_acc_d;
      length_acc_q  <= length_acc_d;
      running_q     <= running_d;
      value_left_q  <= value_left_d;
      seen_q        <= seen_d;
      err_q         <= err_d;
      mtype_q       <= mtype_d;
      tkl_q         <= tkl_d;
      code_q        <= code_d;
      mid_q         <= mid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      role_q   <= role_d;
      byte_q   <= in_byte_i;
      num_q    <= num_d;
      slot_q   <= slot_d;
      len_q    <= len_d;
      end_q    <= in_last_i;
      status_q <= status_d;
      otype_q  <= otype_d;
      otkl_q   <= otkl_d;
      ocode_q  <= ocode_d;
      omid_q   <= omid_d;
      ototal_q <= ototal_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign role_o          = role_q;
  assign out_byte_o      = byte_q;
  assign option_number_o = num_q;
  assign option_slot_o   = slot_q;
  assign option_length_o = len_q;
  assign message_end_o   = end_q;
  assign status_o        = status_q;
  assign message_type_o  = otype_q;
  assign token_length_o  = otkl_q;
  assign message_code_o  = ocode_q;
  assign message_id_o    = omid_q;
  assign option_total_o  = ototal_q;

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> phase_q == PhHeader && seen_q == '0 && err_q == StOk)
    else $error("parser state not cleared after final byte");

  a_mid_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !message_end_o |-> status_o == StOk && option_total_o == 5'd0 &&
    message_id_o == 16'd0)
    else $error("message fields set on a non-final beat");

  a_opt_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && role_o != RoleOptHead && role_o != RoleOptExt && role_o != RoleOptVal
    |-> option_number_o == 16'd0 && option_length_o == 16'd0 && option_slot_o == 4'd0)
    else $error("option fields set on a non-option beat");

endmodule
`default_nettype wire

// ----- tb/tb_coap_message_parser.sv -----
// Testbench for coap_message_parser: byte stream stimulus, parse prediction, per-field checks.
module tb_coap_message_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import coap_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;

  typedef enum logic [2:0] {
    PhHeader, PhToken, PhHead, PhExt, PhValue, PhPayload, PhIgnore
  } parse_phase_e;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  data;
    logic [15:0] opt_num;
    logic [3:0]  opt_slot;
    logic [15:0] opt_len;
    logic        msg_end;
    logic [2:0]  status;
    logic [1:0]  mtype;
    logic [3:0]  tkl;
    logic [7:0]  code;
    logic [15:0] mid;
    logic [4:0]  opt_total;
  } parse_result_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         tx_idle;
    int         rx_stall;
    bit         drain;
  } byte_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  role;
  logic [7:0]  out_byte;
  logic [15:0] option_number;
  logic [3:0]  option_slot;
  logic [15:0] option_length;
  logic        message_end;
  logic [2:0]  status;
  logic [1:0]  message_type;
  logic [3:0]  token_length;
  logic [7:0]  message_code;
  logic [15:0] message_id;
  logic [4:0]  option_total;

  coap_message_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_byte_i       (in_byte),
    .in_last_i       (in_last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .role_o          (role),
    .out_byte_o      (out_byte),
    .option_number_o (option_number),
    .option_slot_o   (option_slot),
    .option_length_o (option_length),
    .message_end_o   (message_end),
    .status_o        (status),
    .message_type_o  (message_type),
    .token_length_o  (token_length),
    .message_code_o  (message_code),
    .message_id_o    (message_id),
    .option_total_o  (option_total)
  );

  byte_beat_t    pending_bytes[$];
  parse_result_t expected_results[$];
  logic [7:0]    msg[$];
  int            cur_tx = 0;
  int            cur_rx = 0;
  bit            drain_next = 0;
  int            rx_stall_pct = 0;
  int            errors = 0;
  int            cycle_count = 0;

  // Parser state of the prediction
  parse_phase_e ph;
  logic [1:0]   hdr_pos;
  logic [3:0]   tok_left;
  logic [1:0]   dmode, lmode, ext_left;
  logic [15:0]  delta_sum, len_sum, opt_base, val_left;
  logic [4:0]   opt_count;
  logic [2:0]   err;
  logic [29:0]  hdr;

  function automatic void reset_parser();
    ph = PhHeader;
    hdr_pos = '0; tok_left = '0; dmode = '0; lmode = '0; ext_left = '0;
    delta_sum = '0; len_sum = '0; opt_base = '0; val_left = '0;
    opt_count = '0; err = StOk; hdr = '0;
  endfunction

  function automatic void close_option();
    opt_base = opt_base + delta_sum;
    opt_count = opt_count + 5'd1;
    delta_sum = '0;
    len_sum = '0;
    ph = PhHead;
  endfunction

  function automatic void finish_head();
    if (len_sum == 16'd0) begin
      close_option();
    end else begin
      val_left = len_sum;
      ph = PhValue;
    end
  endfunction

  function automatic void finish_delta();
    if (lmode == 2'd3) begin
      err = StLength15;
      ph = PhIgnore;
    end else if (lmode != 2'd0) begin
      ext_left = lmode;
      ph = PhExt;
    end else begin
      finish_head();
    end
  endfunction

  function automatic parse_result_t parse_byte(logic [7:0] b, logic last);
    parse_result_t r;
    logic [3:0] dn, ln;
    r = '0;
    r.role = RoleIgnored;
    r.data = b;
    r.msg_end = last;
    case (ph)
      PhHeader: begin
        r.role = RoleHeader;
        case (hdr_pos)
          2'd0: begin
            if (b[7:6] != 2'd1) err = StVersion;
            hdr[29:24] = b[5:0];
          end
          2'd1: hdr[23:16] = b;
          2'd2: hdr[15:8] = b;
          default: hdr[7:0] = b;
        endcase
        if (hdr_pos == 2'd3) begin
          hdr_pos = '0;
          if (err != StOk) begin
            ph = PhIgnore;
          end else if (hdr[27:24] > MaxTokenLen) begin
            err = StToken;
            ph = PhIgnore;
          end else begin
            tok_left = hdr[27:24];
            ph = (tok_left != 4'd0) ? PhToken : PhHead;
          end
        end else begin
          hdr_pos = hdr_pos + 2'd1;
        end
      end
      PhToken: begin
        r.role = RoleToken;
        tok_left = tok_left - 4'd1;
        if (tok_left == 4'd0) ph = PhHead;
      end
      PhHead: begin
        if (b == PayloadMarker) begin
          r.role = RoleMarker;
          ph = PhPayload;
        end else if (opt_count >= MaxOptions) begin
          r.role = RoleIgnored;
          ph = PhIgnore;
        end else begin
          dn = b[7:4];
          ln = b[3:0];
          r.role = RoleOptHead;
          dmode = (dn == Nib13) ? 2'd1 : (dn == Nib14) ? 2'd2 : 2'd0;
          delta_sum = (dn < Nib13) ? {12'd0, dn} : 16'd0;
          lmode = (ln == Nib13) ? 2'd1 : (ln == Nib14) ? 2'd2 : (ln == Nib15) ? 2'd3 : 2'd0;
          len_sum = (ln < Nib13) ? {12'd0, ln} : 16'd0;
          r.opt_num = opt_base + delta_sum;
          r.opt_slot = opt_count[3:0];
          r.opt_len = len_sum;
          if (dn == Nib15) begin
            err = StDelta15;
            ph = PhIgnore;
          end else if (dmode != 2'd0) begin
            ext_left = dmode;
            ph = PhExt;
          end else begin
            finish_delta();
          end
        end
      end
      PhExt: begin
        r.role = RoleOptExt;
        if (dmode != 2'd0) begin
          if (ext_left == 2'd2) begin
            delta_sum = {b, 8'h00};
            ext_left = 2'd1;
          end else begin
            delta_sum = (dmode == 2'd1) ? {8'h00, b} + Ext1Off : (delta_sum | b) + Ext2Off;
            dmode = 2'd0;
            ext_left = 2'd0;
          end
          r.opt_num = opt_base + delta_sum;
          r.opt_slot = opt_count[3:0];
          r.opt_len = len_sum;
          if (dmode == 2'd0) finish_delta();
        end else begin
          if (ext_left == 2'd2) begin
            len_sum = {b, 8'h00};
            ext_left = 2'd1;
          end else begin
            len_sum = (lmode == 2'd1) ? {8'h00, b} + Ext1Off : (len_sum | b) + Ext2Off;
            lmode = 2'd0;
            ext_left = 2'd0;
          end
          r.opt_num = opt_base + delta_sum;
          r.opt_slot = opt_count[3:0];
          r.opt_len = len_sum;
          if (lmode == 2'd0) finish_head();
        end
      end
      PhValue: begin
        r.role = RoleOptVal;
        r.opt_num = opt_base + delta_sum;
        r.opt_slot = opt_count[3:0];
        r.opt_len = len_sum;
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) close_option();
      end
      PhPayload: r.role = RolePayload;
      default: r.role = RoleIgnored;
    endcase
    if (last) begin
      if (ph == PhHeader) r.status = StHdrShort;
      else if (err != StOk) r.status = err;
      else if (ph == PhToken) r.status = StToken;
      else if (ph == PhExt) r.status = StOptShort;
      else if (ph == PhValue) r.status = StOptBig;
      else r.status = StOk;
      r.mtype = hdr[29:28];
      r.tkl = hdr[27:24];
      r.code = hdr[23:16];
      r.mid = hdr[15:0];
      r.opt_total = opt_count;
      reset_parser();
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic put(logic [7:0] b);
    msg.push_back(b);
  endtask

  task automatic put_header(logic [1:0] ver, logic [1:0] mtype, logic [3:0] tkl,
                            logic [7:0] code, logic [15:0] mid);
    put({ver, mtype, tkl});
    put(code);
    put(mid[15:8]);
    put(mid[7:0]);
  endtask

  task automatic send_msg();
    byte_beat_t beat;
    for (int i = 0; i < msg.size(); i++) begin
      beat.data = msg[i];
      beat.last = (i == msg.size() - 1);
      beat.tx_idle = cur_tx;
      beat.rx_stall = cur_rx;
      beat.drain = drain_next && (i == 0);
      pending_bytes.push_back(beat);
    end
    drain_next = 0;
    msg.delete();
  endtask

  task automatic put_random_option();
    int dsel, lsel, nval;
    logic [3:0] dnib, lnib;
    logic [7:0] d0, d1, l0, l1;
    logic [15:0] vlen;
    dsel = $urandom_range(0, 19);
    lsel = $urandom_range(0, 19);
    d0 = 8'($urandom_range(0, 255));
    d1 = 8'($urandom_range(0, 255));
    l0 = 8'($urandom_range(0, 255));
    l1 = 8'($urandom_range(0, 255));
    if (dsel < 12) dnib = 4'($urandom_range(0, 12));
    else if (dsel < 16) dnib = Nib13;
    else if (dsel < 19) dnib = Nib14;
    else dnib = Nib15;
    if (lsel < 14) begin
      lnib = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(5, 12)) : 4'($urandom_range(0, 4));
      vlen = {12'd0, lnib};
    end else if (lsel < 17) begin
      lnib = Nib13;
      l0 = 8'($urandom_range(0, 3));
      vlen = {8'h00, l0} + Ext1Off;
    end else if (lsel < 19) begin
      lnib = Nib14;
      if ($urandom_range(0, 1) == 1) begin
        l0 = 8'hFE;
        l1 = 8'($urandom_range(8'hF3, 8'hFF));
      end
      vlen = {l0, l1} + Ext2Off;
    end else begin
      lnib = Nib15;
      vlen = '0;
    end
    put({dnib, lnib});
    if (dnib == Nib13) begin
      put(d0);
    end else if (dnib == Nib14) begin
      put(d0);
      put(d1);
    end
    if (lnib == Nib13) begin
      put(l0);
    end else if (lnib == Nib14) begin
      put(l0);
      put(l1);
    end
    nval = (vlen > 16'd20) ? 20 : int'(vlen);
    repeat (nval) put(8'($urandom_range(0, 255)));
  endtask

  task automatic put_random_message();
    int kind, nopt, cut, npay;
    logic [1:0] ver;
    logic [3:0] tkl;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
    end else begin
      ver = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : 2'd1;
      tkl = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      put_header(ver, 2'($urandom_range(0, 3)), tkl, 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)));
      repeat (tkl) put(8'($urandom_range(0, 255)));
      nopt = ($urandom_range(0, 14) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
      repeat (nopt) put_random_option();
      case ($urandom_range(0, 3))
        0: ;
        1: put(PayloadMarker);
        default: begin
          put(PayloadMarker);
          npay = $urandom_range(1, 8);
          repeat (npay) put(8'($urandom_range(0, 255)));
        end
      endcase
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, msg.size());
        msg = msg[0:cut-1];
      end
    end
    send_msg();
  endtask

  task automatic build_stimulus();
    int target;
    // short header, also with a bad version
    put(8'h40); send_msg();
    put(8'h00); put(8'h12); send_msg();
    // bad version over a full header
    put_header(2'd2, 2'd0, 4'd0, 8'h01, 16'h1234); put(8'h11); send_msg();
    // token length over 8
    put_header(2'd1, 2'd3, 4'd15, 8'hFF, 16'hFFFF); put(8'h00); send_msg();
    // ends inside the token
    put_header(2'd1, 2'd1, 4'd2, 8'h01, 16'h0001); put(8'hAB); send_msg();
    // extensions of both sizes, 16-bit wrap, marker and payload
    put_header(2'd1, 2'd2, 4'd8, 8'h45, 16'hBEEF);
    for (int i = 0; i < 8; i++) put(8'(i));
    put(8'hD1); put(8'hFF); put(8'h5A);
    put(8'hE0); put(8'hFF); put(8'hFF);
    put(8'h0D); put(8'h00);
    repeat (13) put(8'hC3);
    put(8'h0E); put(8'hFE); put(8'hF4); put(8'h00);
    put(PayloadMarker); put(8'h00); put(8'hFF);
    send_msg();
    // delta 15, length 15, length 15 after delta extension
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(8'hF0); put(8'h01); send_msg();
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(8'h0F); send_msg();
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(8'hDF); put(8'h05); send_msg();
    // ends inside extensions and inside a value
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(8'hDF); send_msg();
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(8'hE0); put(8'h12); send_msg();
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(8'h03); put(8'hAA); send_msg();
    // marker as final byte, bare header, token ending the message
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102); put(PayloadMarker); send_msg();
    put_header(2'd1, 2'd0, 4'd0, 8'h00, 16'h0000); send_msg();
    put_header(2'd1, 2'd0, 4'd1, 8'h02, 16'h8000); put(8'h77); send_msg();
    // option limit: extra option ignored, then marker after the limit
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102);
    repeat (17) put(8'h00);
    put(8'h11); put(PayloadMarker); send_msg();
    put_header(2'd1, 2'd0, 4'd0, 8'h01, 16'h0102);
    repeat (16) put(8'h10);
    put(PayloadMarker); put(8'h42); send_msg();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin cur_tx = 0;  cur_rx = 0;  end
        1: begin cur_tx = 52; cur_rx = 0;  end
        2: begin cur_tx = 0;  cur_rx = 52; end
        default: begin cur_tx = 35; cur_rx = 35; end
      endcase
      drain_next = 1;
      target = pending_bytes.size() + 150;
      while (pending_bytes.size() < target) put_random_message();
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    byte_beat_t beat;
    bit go;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte <= '0;
      in_last <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(parse_byte(in_byte, in_last));
      if (!in_valid || !in_stall) begin
        go = pending_bytes.size() != 0;
        if (go && pending_bytes[0].drain) go = expected_results.size() == 0 && !in_valid;
        if (go && $urandom_range(0, 99) < pending_bytes[0].tx_idle) go = 0;
        if (go) begin
          beat = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte <= beat.data;
          in_last <= beat.last;
          rx_stall_pct <= beat.rx_stall;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    parse_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation: byte %0h", out_byte);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("role", want.role, role);
          check_field("out_byte", want.data, out_byte);
          check_field("option_number", want.opt_num, option_number);
          check_field("option_slot", want.opt_slot, option_slot);
          check_field("option_length", want.opt_len, option_length);
          check_field("message_end", want.msg_end, message_end);
          check_field("status", want.status, status);
          check_field("message_type", want.mtype, message_type);
          check_field("token_length", want.tkl, token_length);
          check_field("message_code", want.code, message_code);
          check_field("message_id", want.mid, message_id);
          check_field("option_total", want.opt_total, option_total);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_coap_message_parser failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    reset_parser();
    build_stimulus();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_coap_message_parser passed");
    end else begin
      $display("tb_coap_message_parser failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/coap_pkg.sv
src/coap_message_parser.sv
tb/tb_coap_message_parser.sv
